FILE: hw/rtl/multi_channel_servo_pwm_assert.svh
// Assertion macros for the servo PWM block.
`ifndef MULTI_CHANNEL_SERVO_PWM_ASSERT_SVH
`define MULTI_CHANNEL_SERVO_PWM_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCSP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("servo pwm assertion failed");

// Next-cycle implication, checked outside reset.
`define MCSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("servo pwm assertion failed");

`endif

FILE: hw/rtl/mcsp_pkg.sv
// Shared types and constants for the servo PWM block.
package mcsp_pkg;

    localparam int NUM_SLOTS  = 4;
    localparam int DUTY_W     = 12;
    localparam int CNT_W      = 16;
    localparam int PULSE_W    = 16;
    localparam int LIMIT_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_ENABLE  = 2'd2;
    localparam logic [1:0] CMD_DISABLE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 2'd2;

    localparam logic [CNT_W-1:0]   RST_PERIOD    = 16'd2222;
    localparam logic [LIMIT_W-1:0] RST_MIN_PULSE = 12'd400;
    localparam logic [LIMIT_W-1:0] RST_MAX_PULSE = 12'd2100;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         channel;
        logic [PULSE_W-1:0] pulse_us;
    } t_in_item;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] pin_levels;
        logic [15:0]          readback_us;
    } t_out_item;

    typedef struct packed {
        logic [LIMIT_W-1:0] min_us;
        logic [LIMIT_W-1:0] max_us;
    } t_clamp_cfg;

endpackage

FILE: hw/rtl/multi_channel_servo_pwm.sv
// Top level of the four-channel servo PWM generator.
// Takes one item per clock while the input is not stalled and returns one result per
// item; the input, state-update and readback registers form a three-deep pipeline,
// and the frame counter, duty, enable and pin state are all updated as an item moves
// into the middle stage. Readback is the stored duty times TICK_US, saturated at 65535.
// Configuration ready is always high; write registers only while no item is in flight.
// No clearing pass after reset.
module multi_channel_servo_pwm #(
    parameter int TICK_US  = 9,
    parameter int CHANNELS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mcsp_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output mcsp_pkg::t_out_item                o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mcsp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mcsp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int NS    = mcsp_pkg::NUM_SLOTS;
    localparam int DW    = mcsp_pkg::DUTY_W;
    localparam int CW    = mcsp_pkg::CNT_W;
    localparam int TickW = $clog2(TICK_US + 1);
    localparam int RbW   = DW + TickW;

    logic [CW-1:0]          r_period;
    mcsp_pkg::t_clamp_cfg   r_limits;

    logic [CW-1:0]          r_cnt,   n_cnt;
    logic [DW-1:0]          r_duty   [NS];
    logic [DW-1:0]          n_duty   [NS];
    logic [NS-1:0]          r_en,    n_en;
    logic [NS-1:0]          r_pin,   n_pin;

    logic                   r_in_valid, r_mid_valid, r_out_valid;
    mcsp_pkg::t_in_item     r_in;
    logic [NS-1:0]          r_mid_pins;
    logic [DW-1:0]          r_mid_duty, n_mid_duty;
    mcsp_pkg::t_out_item    r_out;

    logic                   a_go, b_go, in_xfer;
    logic                   ch_valid;
    logic [CW-1:0]          cnt_base;
    logic [DW-1:0]          conv_duty;
    logic [RbW-1:0]         rb_prod;
    logic [15:0]            rb_sat;

    assign b_go       = r_mid_valid && (!r_out_valid || !i_out_stall);
    assign a_go       = r_in_valid && (!r_mid_valid || b_go);
    assign o_in_stall = r_in_valid && !a_go;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign ch_valid = int'(r_in.channel) < CHANNELS;
    assign cnt_base = (r_cnt >= r_period) ? '0 : r_cnt;

    mcsp_pulse_conv #(
        .TICK_US (TICK_US)
    ) u_conv (
        .i_pulse_us (r_in.pulse_us),
        .i_limits   (r_limits),
        .o_duty     (conv_duty)
    );

    always_comb begin
        n_cnt  = r_cnt;
        n_duty = r_duty;
        n_en   = r_en;
        n_pin  = r_pin;
        if (a_go) begin
            unique case (r_in.cmd)
                mcsp_pkg::CMD_TICK: begin
                    for (int i = 0; i < NS; i++) begin
                        if (r_duty[i] != '0) begin
                            n_pin[i] = cnt_base < CW'(r_duty[i]);
                        end
                    end
                    n_cnt = cnt_base + CW'(1);
                end
                mcsp_pkg::CMD_WRITE: begin
                    if (ch_valid && r_en[r_in.channel]) begin
                        n_duty[r_in.channel] = conv_duty;
                    end
                end
                mcsp_pkg::CMD_ENABLE: begin
                    if (ch_valid) begin
                        n_en[r_in.channel] = 1'b1;
                    end
                end
                mcsp_pkg::CMD_DISABLE: begin
                    if (ch_valid) begin
                        n_en[r_in.channel]   = 1'b0;
                        n_duty[r_in.channel] = '0;
                        n_pin[r_in.channel]  = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        n_mid_duty = ch_valid ? n_duty[r_in.channel] : '0;
    end

    assign rb_prod = RbW'(r_mid_duty) * RbW'(TICK_US);
    assign rb_sat  = (32'(rb_prod) > 32'hFFFF) ? 16'hFFFF : 16'(rb_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= mcsp_pkg::RST_PERIOD;
            r_limits    <= '{min_us: mcsp_pkg::RST_MIN_PULSE,
                             max_us: mcsp_pkg::RST_MAX_PULSE};
            r_cnt       <= '0;
            r_en        <= '0;
            r_pin       <= '0;
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                r_duty[i] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    mcsp_pkg::REG_PERIOD:    r_period <= i_cfg_data;
                    mcsp_pkg::REG_MIN_PULSE:
                        r_limits.min_us <= i_cfg_data[mcsp_pkg::LIMIT_W-1:0];
                    mcsp_pkg::REG_MAX_PULSE:
                        r_limits.max_us <= i_cfg_data[mcsp_pkg::LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_cnt  <= n_cnt;
            r_duty <= n_duty;
            r_en   <= n_en;
            r_pin  <= n_pin;

            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (a_go) begin
                r_in_valid <= 1'b0;
            end
            if (a_go) begin
                r_mid_valid <= 1'b1;
            end else if (b_go) begin
                r_mid_valid <= 1'b0;
            end
            if (b_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_item;
        end
        if (a_go) begin
            r_mid_pins <= n_pin;
            r_mid_duty <= n_mid_duty;
        end
        if (b_go) begin
            r_out.pin_levels  <= r_mid_pins;
            r_out.readback_us <= rb_sat;
        end
    end

`include "multi_channel_servo_pwm_assert.svh"

    `MCSP_ASSERT_NEXT(a_tick_cnt_nonzero, a_go && r_in.cmd == mcsp_pkg::CMD_TICK, r_cnt != '0)
    `MCSP_ASSERT_NEXT(a_disable_clears,
        a_go && r_in.cmd == mcsp_pkg::CMD_DISABLE && ch_valid,
        r_duty[$past(r_in.channel)] == '0 && !r_en[$past(r_in.channel)])
    `MCSP_ASSERT_NEXT(a_enable_sets,
        a_go && r_in.cmd == mcsp_pkg::CMD_ENABLE && ch_valid, r_en[$past(r_in.channel)])
    `MCSP_ASSERT_NOW(a_stall_only_when_full, o_in_stall, r_in_valid && r_mid_valid)

endmodule

FILE: hw/rtl/mcsp_pulse_conv.sv
// Pulse clamp and conversion from microseconds to duty ticks.
module mcsp_pulse_conv #(
    parameter int TICK_US = 9
) (
    input  logic [mcsp_pkg::PULSE_W-1:0] i_pulse_us,
    input  mcsp_pkg::t_clamp_cfg         i_limits,
    output logic [mcsp_pkg::DUTY_W-1:0]  o_duty
);

    localparam int TickW      = $clog2(TICK_US + 1);
    localparam int RecipShift = mcsp_pkg::DUTY_W + TickW + 1;
    localparam int RecipW     = RecipShift + 1;
    localparam int ProdW      = mcsp_pkg::DUTY_W + RecipW;
    localparam logic [RecipW-1:0] Recip =
        RecipW'(((64'd1 << RecipShift) + 64'(TICK_US) - 64'd1) / 64'(TICK_US));

    logic [mcsp_pkg::DUTY_W-1:0] clamped;
    logic [ProdW-1:0]            prod;

    always_comb begin
        // upper bound is tested first, so with crossed bounds a pulse above max gives max and any other gives min
        priority if (i_pulse_us > mcsp_pkg::PULSE_W'(i_limits.max_us)) begin
            clamped = i_limits.max_us;
        end else if (i_pulse_us < mcsp_pkg::PULSE_W'(i_limits.min_us)) begin
            clamped = i_limits.min_us;
        end else begin
            clamped = i_pulse_us[mcsp_pkg::DUTY_W-1:0];
        end
    end

    assign prod   = ProdW'(clamped) * ProdW'(Recip);
    assign o_duty = prod[RecipShift +: mcsp_pkg::DUTY_W];

endmodule
